// ===== rtl/u2ue_pkg.sv =====
// Shared types and constants of the UTF-8 to \u escape block.
package u2ue_pkg;

  localparam int CODE_W = 21;

  // What the back end has to emit for one job.
  typedef enum logic [1:0] {
    JOB_CHAR = 2'd0,  // one raw character
    JOB_CODE = 2'd1,  // backslash, 'u', 4 to 6 hex digits
    JOB_ERR  = 2'd2   // one error result
  } job_kind_t;

  typedef struct packed {
    job_kind_t           kind;
    logic [CODE_W-1:0]   data;      // char in [7:0] or code point
    logic [2:0]          last_idx;  // index of the last character
    logic                str_end;   // job closes the string
  } job_t;

endpackage

// ===== rtl/utf8_to_unicode_escape.sv =====
// Top level of the UTF-8 to \u escape converter.
//
// Input channel (in_valid / in_stall): one byte of a UTF-8 string per
// transaction, string_end high on the last byte of the string.
// Output channel (out_valid / out_stall): one character of escaped text per
// transaction. run_last closes the characters caused by one input byte,
// string_done the whole string, error flags a bad lead byte or a truncated
// sequence (out_char then reads zero).
// A byte's job passes the job queue and the back end's job register before
// its first character reaches the output register. The back end serializer
// sends one character per cycle while the output does not stall: an ASCII
// byte gives one character, a finished code point one (zero value) or 6 to 8,
// bytes that open or extend a sequence none. The front end keeps taking one
// byte per cycle as long as the job queue has room; QDEPTH jobs can wait.
// Reset clears the sequence state, the queue and the output valid flag.
// A stall on the output holds the current character; the queue then fills
// and in_stall rises, so no transaction is ever lost.
module utf8_to_unicode_escape #(
  parameter int QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       string_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       run_last,
  output logic       string_done,
  output logic       error
);

  u2ue_pkg::job_t wr_job;
  u2ue_pkg::job_t rd_job;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  // byte decode and sequence tracking
  u2ue_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .string_end (string_end),
    .q_full     (q_full),
    .push       (push),
    .job        (wr_job)
  );

  // decouples decode from character emission
  u2ue_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_job),
    .pop     (pop),
    .rd_data (rd_job),
    .full    (q_full),
    .empty   (q_empty)
  );

  // character serializer with registered output
  u2ue_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_data      (rd_job),
    .q_empty     (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .run_last    (run_last),
    .string_done (string_done),
    .error       (error)
  );

endmodule

// ===== rtl/u2ue_front.sv =====
// Front end: takes input bytes, tracks the UTF-8 sequence and issues jobs.
module u2ue_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            string_end,
  input  logic            q_full,
  output logic            push,
  output u2ue_pkg::job_t  job
);

  logic [u2ue_pkg::CODE_W-1:0] code_bits, code_bits_next, cp_shift;
  logic [1:0]                  bytes_left, bytes_left_next;
  logic [7:0]                  lead_byte, lead_byte_next;
  logic                        error_drop, error_drop_next;
  logic                        accept;
  logic                        has_job;
  logic                        err;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cp_shift = {code_bits[u2ue_pkg::CODE_W-7:0], in_byte[5:0]};

  always_comb begin
    code_bits_next  = code_bits;
    bytes_left_next = bytes_left;
    lead_byte_next  = lead_byte;
    error_drop_next = error_drop;
    has_job         = 1'b0;
    err             = 1'b0;
    job.kind        = u2ue_pkg::JOB_CHAR;
    job.data        = {{(u2ue_pkg::CODE_W-8){1'b0}}, in_byte};
    job.last_idx    = 3'd0;
    job.str_end     = string_end;

    if (error_drop) begin
      // dropping until the end of the string
    end else if (bytes_left != 2'd0) begin
      code_bits_next  = cp_shift;
      bytes_left_next = bytes_left - 2'd1;
      if (bytes_left == 2'd1) begin
        has_job = 1'b1;
        if (cp_shift == '0) begin
          job.data = {{(u2ue_pkg::CODE_W-8){1'b0}}, lead_byte};
        end else begin
          job.kind = u2ue_pkg::JOB_CODE;
          job.data = cp_shift;
          if (cp_shift > 21'hFFFFF) begin
            job.last_idx = 3'd7;
          end else if (cp_shift > 21'h0FFFF) begin
            job.last_idx = 3'd6;
          end else begin
            job.last_idx = 3'd5;
          end
        end
      end else if (string_end) begin
        err = 1'b1;
      end
    end else if (in_byte <= 8'h7F) begin
      has_job = 1'b1;
    end else if (in_byte <= 8'hF7) begin
      lead_byte_next = in_byte;
      if (in_byte <= 8'hDF) begin
        code_bits_next  = {{(u2ue_pkg::CODE_W-5){1'b0}}, in_byte[4:0]};
        bytes_left_next = 2'd1;
      end else if (in_byte <= 8'hEF) begin
        code_bits_next  = {{(u2ue_pkg::CODE_W-4){1'b0}}, in_byte[3:0]};
        bytes_left_next = 2'd2;
      end else begin
        code_bits_next  = {{(u2ue_pkg::CODE_W-3){1'b0}}, in_byte[2:0]};
        bytes_left_next = 2'd3;
      end
      if (string_end) begin
        err = 1'b1;
      end
    end else begin
      err = 1'b1;
    end

    if (err) begin
      has_job         = 1'b1;
      job.kind        = u2ue_pkg::JOB_ERR;
      job.data        = '0;
      job.last_idx    = 3'd0;
      job.str_end     = 1'b1;
      error_drop_next = !string_end;
    end
    if (err || string_end) begin
      code_bits_next  = '0;
      bytes_left_next = 2'd0;
      lead_byte_next  = 8'h00;
    end
    if (string_end && !err) begin
      error_drop_next = 1'b0;
    end
  end

  assign push = accept && has_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_bits  <= '0;
      bytes_left <= 2'd0;
      lead_byte  <= 8'h00;
      error_drop <= 1'b0;
    end else if (accept) begin
      code_bits  <= code_bits_next;
      bytes_left <= bytes_left_next;
      lead_byte  <= lead_byte_next;
      error_drop <= error_drop_next;
    end
  end

`ifndef ASSERT_OFF
  // while dropping no sequence may be open
  a_drop_no_seq: assert property (@(posedge clk) disable iff (rst)
    error_drop |-> bytes_left == 2'd0)
    else $error("sequence open while dropping");
`endif

endmodule

// ===== rtl/u2ue_queue.sv =====
// Job queue between the front end and the back end.
module u2ue_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u2ue_pkg::job_t  wr_data,
  input  logic            pop,
  output u2ue_pkg::job_t  rd_data,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u2ue_pkg::job_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("queue underflow");
`endif

endmodule

// ===== rtl/u2ue_back.sv =====
// Back end: expands jobs into output characters, one per cycle while the output does not stall.
module u2ue_back (
  input  logic                 clk,
  input  logic                 rst,
  input  u2ue_pkg::job_t       q_data,
  input  logic                 q_empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_char,
  output logic                 run_last,
  output logic                 string_done,
  output logic                 error
);

  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_U      = 8'h75;

  u2ue_pkg::job_t cur;
  logic           cur_valid;
  logic [2:0]     cur_idx;
  logic [2:0]     pos;
  logic [3:0]     nibble;
  logic [7:0]     char_next;
  logic           fire;
  logic           is_last;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = 8'h30 + {4'h0, v};
    end else begin
      c = 8'h37 + {4'h0, v};
    end
    return c;
  endfunction

  assign fire    = cur_valid && (!out_valid || !out_stall);
  assign is_last = cur_idx == cur.last_idx;
  assign pop     = !q_empty && (!cur_valid || (fire && is_last));
  assign pos     = cur.last_idx - cur_idx;

  always_comb begin
    case (pos)
      3'd0:    nibble = cur.data[3:0];
      3'd1:    nibble = cur.data[7:4];
      3'd2:    nibble = cur.data[11:8];
      3'd3:    nibble = cur.data[15:12];
      3'd4:    nibble = cur.data[19:16];
      3'd5:    nibble = {3'b000, cur.data[20]};
      default: nibble = 4'h0;
    endcase
  end

  always_comb begin
    unique case (cur.kind)
      u2ue_pkg::JOB_CHAR: char_next = cur.data[7:0];
      u2ue_pkg::JOB_CODE: begin
        if (cur_idx == 3'd0) begin
          char_next = CHAR_BSLASH;
        end else if (cur_idx == 3'd1) begin
          char_next = CHAR_U;
        end else begin
          char_next = hex_char(nibble);
        end
      end
      default: char_next = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_idx   <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        cur_idx   <= 3'd0;
      end else if (fire) begin
        cur_valid <= !is_last;
        cur_idx   <= cur_idx + 3'd1;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
    if (fire) begin
      out_char    <= char_next;
      run_last    <= is_last;
      string_done <= is_last && cur.str_end;
      error       <= cur.kind == u2ue_pkg::JOB_ERR;
    end
  end

`ifndef ASSERT_OFF
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> run_last && string_done && out_char == 8'h00)
    else $error("malformed error result");
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_done |-> run_last)
    else $error("string_done without run_last");
`endif

endmodule

// ===== verif/utf8_to_unicode_escape_tb.sv =====
// Self-checking testbench for the UTF-8 to \u escape converter.
module utf8_to_unicode_escape_tb;

  // Byte classes of a UTF-8 lead
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MAX = 8'hF7;
  localparam logic [7:0] CONT_TAG  = 8'h80;  // continuation byte, no payload

  // Characters of the escape text
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h41;

  // Pacing modes: back to back, light gaps, full 0..16 gaps
  localparam int PACE_BURST = 0;
  localparam int PACE_LIGHT = 1;
  localparam int PACE_HEAVY = 2;

  localparam int RANDOM_BYTES = 330;
  localparam int DRAIN_POINT  = 170;   // sender waits for an empty scoreboard here
  localparam int TAIL_CYCLES  = 20;

  // One character of escaped output as it is expected on the output port
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       done;
    logic       err;
  } esc_char_t;

  // Escaper model plus the queue of characters still owed by the block.
  class escape_scoreboard;
    logic [20:0] code_acc;
    logic [1:0]  need;
    logic [7:0]  lead;
    bit          dropping;
    esc_char_t   owed_q[$];
    int          errors;

    function new();
      clear_seq();
      errors = 0;
    endfunction

    function void clear_seq();
      code_acc = '0;
      need     = '0;
      lead     = '0;
      dropping = 1'b0;
    endfunction

    function void owe(logic [7:0] c);
      owed_q.push_back('{ch: c, last: 1'b0, done: 1'b0, err: 1'b0});
    endfunction

    // Backslash, 'u' and 4..6 uppercase hex digits; a zero code point is the raw lead.
    function void owe_code();
      int digits;
      logic [3:0] nib;
      if (code_acc == '0) begin
        owe(lead);
        return;
      end
      digits = (code_acc > 21'hFFFFF) ? 6 : (code_acc > 21'hFFFF) ? 5 : 4;
      owe(CH_BSLASH);
      owe(CH_U);
      for (int i = digits - 1; i >= 0; i--) begin
        nib = 4'(code_acc >> (4 * i));
        owe((nib < 10) ? CH_ZERO + 8'(nib) : CH_A + 8'(nib) - 8'd10);
      end
    endfunction

    // Called for every accepted input transaction.
    function void note_byte(logic [7:0] b, logic fin);
      int first;
      bit bad;
      esc_char_t tail;
      first = owed_q.size();
      bad = 1'b0;
      if (dropping) begin
        if (fin) clear_seq();
        return;
      end
      if (need != 0) begin
        code_acc = {code_acc[14:0], b[5:0]};
        need = need - 2'd1;
        if (need == 0) owe_code();
        else if (fin) bad = 1'b1;
      end else if (b <= ASCII_MAX) begin
        owe(b);
      end else if (b <= LEAD4_MAX) begin
        lead = b;
        if (b <= LEAD2_MAX) begin
          code_acc = 21'(b[4:0]);
          need = 2'd1;
        end else if (b <= LEAD3_MAX) begin
          code_acc = 21'(b[3:0]);
          need = 2'd2;
        end else begin
          code_acc = 21'(b[2:0]);
          need = 2'd3;
        end
        if (fin) bad = 1'b1;
      end else begin
        bad = 1'b1;
      end

      if (bad) begin
        // single error character; it always closes the string's output
        owed_q.push_back('{ch: 8'h00, last: 1'b1, done: 1'b1, err: 1'b1});
        clear_seq();
        dropping = !fin;
        return;
      end
      if (owed_q.size() > first) begin
        tail = owed_q.pop_back();
        tail.last = 1'b1;
        tail.done = fin;
        owed_q.push_back(tail);
      end
      if (fin) clear_seq();
    endfunction

    // Called for every accepted output transaction.
    function void check_char(logic [7:0] c, logic rl, logic sd, logic e);
      esc_char_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output: expected nothing,", $time);
        $display("%0t:   got char %h run_last %b string_done %b error %b",
                 $time, c, rl, sd, e);
        return;
      end
      want = owed_q.pop_front();
      if (c !== want.ch || rl !== want.last || sd !== want.done || e !== want.err) begin
        errors++;
        $display("%0t: mismatch: expected char %h run_last %b string_done %b error %b",
                 $time, want.ch, want.last, want.done, want.err);
        $display("%0t:           got      char %h run_last %b string_done %b error %b",
                 $time, c, rl, sd, e);
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       string_end;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_char;
  logic       run_last;
  logic       string_done;
  logic       error;

  escape_scoreboard sb = new();

  int bytes_sent  = 0;
  int sender_pace = PACE_HEAVY;
  int recv_pace   = PACE_HEAVY;

  utf8_to_unicode_escape dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .string_end  (string_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .run_last    (run_last),
    .string_done (string_done),
    .error       (error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap(int pace);
    case (pace)
      PACE_BURST: return 0;
      PACE_LIGHT: return $urandom_range(0, 2);
      default:    return $urandom_range(0, 16);
    endcase
  endfunction

  // Continuation bytes are not checked by the block, so now and then send junk.
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return CONT_TAG | 8'($urandom_range(0, 63));
  endfunction

  // Inputs move only at the falling edge. A back-to-back transaction keeps
  // in_valid high and just swaps the payload, so each signal is written once per step.
  task automatic send_byte(logic [7:0] b, logic fin);
    int gap;
    gap = pick_gap(sender_pace);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid   = 1'b1;
    in_byte    = b;
    string_end = fin;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_string(logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
  endtask

  // Mostly well-formed text with random content; some noise, bad leads and cut strings.
  task automatic send_random_string();
    logic [7:0] seq[$];
    int nchar;
    int kind;
    int cut;
    nchar = $urandom_range(1, 6);
    for (int i = 0; i < nchar; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        seq.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 55) begin
        seq.push_back(8'($urandom_range(8'h80, LEAD2_MAX)));
        seq.push_back(cont_byte());
      end else if (kind < 70) begin
        seq.push_back(8'($urandom_range(LEAD2_MAX + 1, LEAD3_MAX)));
        repeat (2) seq.push_back(cont_byte());
      end else if (kind < 85) begin
        seq.push_back(8'($urandom_range(LEAD3_MAX + 1, LEAD4_MAX)));
        repeat (3) seq.push_back(cont_byte());
      end else if (kind < 90) begin
        // overlong zero: the raw lead comes out
        case ($urandom_range(0, 2))
          0: seq.push_back(8'hC0);
          1: begin
            seq.push_back(8'hE0);
            seq.push_back(CONT_TAG);
          end
          default: begin
            seq.push_back(8'hF0);
            repeat (2) seq.push_back(CONT_TAG);
          end
        endcase
        seq.push_back(CONT_TAG);
      end else if (kind < 94) begin
        seq.push_back(8'($urandom_range(LEAD4_MAX + 1, 8'hFF)));
      end else begin
        seq.push_back(8'($urandom_range(0, 255)));
      end
    end
    // occasionally chop the tail so the string may end inside a sequence
    if ($urandom_range(0, 7) == 0 && seq.size() > 1) begin
      cut = $urandom_range(1, seq.size() - 1);
      while (seq.size() > cut) void'(seq.pop_back());
    end
    send_string(seq);
  endtask

  // Output side: draw a stall length per character, then take it.
  initial begin
    int stall_len;
    int taken;
    out_stall = 1'b1;
    taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken % 40 == 0) recv_pace = $urandom_range(PACE_BURST, PACE_HEAVY);
      stall_len = pick_gap(recv_pace);
      repeat (stall_len) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      taken++;
    end
  end

  // Every output transaction is checked against the oldest owed character.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_char(out_char, run_last, string_done, error);
  end

  initial begin
    bit drained;
    drained    = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_byte    = 8'h00;
    string_end = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: NUL and DEL pass through, 2- and 3-byte sequences in one string
    send_string('{8'h00, ASCII_MAX, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC});
    // largest code point, six hex digits
    send_string('{LEAD4_MAX, 8'hBF, 8'hBF, 8'hBF});
    // five hex digits, then an overlong zero that emits its raw lead
    send_string('{8'hF0, 8'h90, CONT_TAG, CONT_TAG, 8'hC0, CONT_TAG});
    // continuation-range byte taken as a 2-byte lead
    send_string('{8'hBF, 8'hBF});
    // bad lead, then bytes dropped up to string end
    send_string('{8'hF8, CH_A, 8'hFF});
    // lead byte that carries string end
    send_string('{LEAD2_MAX + 8'd1});
    // string cut inside a 3-byte sequence
    send_string('{8'hE2, 8'h82});
    // good output followed by a bad lead on the last byte
    send_string('{CH_A, 8'hFF});

    // Random strings
    while (bytes_sent < RANDOM_BYTES) begin
      sender_pace = $urandom_range(PACE_BURST, PACE_HEAVY);
      if (!drained && bytes_sent >= DRAIN_POINT) begin
        // drop valid, then hold off until the block has flushed everything it owes
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        drained = 1'b1;
      end
      send_random_string();
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== utf8_to_unicode_escape.f =====
rtl/u2ue_pkg.sv
rtl/u2ue_front.sv
rtl/u2ue_queue.sv
rtl/u2ue_back.sv
rtl/utf8_to_unicode_escape.sv
verif/utf8_to_unicode_escape_tb.sv
